// ===== src/bci_pkg.sv =====
`timescale 1ns / 1ps

package bci_pkg;

	localparam int FIELD_W          = 7;
	localparam int STEP_W           = 6;
	localparam int RESULT_WIDTH_DEF = 64;
	localparam int QUEUE_DEPTH      = 2;
	localparam int RADIX_BITS       = 4;

	typedef struct packed {
		logic               trivial;
		logic               one;
		logic [FIELD_W-1:0] n;
		logic [STEP_W-1:0]  kk;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_STEP,
		ST_OUT
	} state_t;

endpackage

// ===== src/bci_front.sv =====
`timescale 1ns / 1ps

module bci_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [bci_pkg::FIELD_W-1:0] n,
	input  logic [bci_pkg::FIELD_W-1:0] k,
	output logic                        push_valid,
	input  logic                        push_ready,
	output bci_pkg::job_t               push_data
);

	logic                        valid_s1;
	bci_pkg::job_t               job_s1;
	bci_pkg::job_t               job_nx;
	logic [bci_pkg::FIELD_W-1:0] nk;
	logic [bci_pkg::FIELD_W-1:0] kk_full;

	// classify: k above n gives zero, k at an edge gives one, else loop on min(k, n-k)
	always_comb begin
		nk      = n - k;
		kk_full = (k > nk) ? nk : k;
		job_nx.trivial = (k > n) || (k == '0) || (k == n);
		job_nx.one     = (k <= n);
		job_nx.n       = n;
		job_nx.kk      = kk_full[bci_pkg::STEP_W-1:0];
	end

	assign req_ready  = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_data  = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			job_s1 <= job_nx;
		end
	end

endmodule

// ===== src/bci_queue.sv =====
`timescale 1ns / 1ps

module bci_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  bci_pkg::job_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output bci_pkg::job_t pop_data
);

	localparam int PW = $clog2(bci_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(bci_pkg::QUEUE_DEPTH + 1);

	bci_pkg::job_t entry_q [bci_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign push_ready = (count_q != CW'(bci_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== src/bci_back.sv =====
`timescale 1ns / 1ps

module bci_back #(
	parameter int RESULT_WIDTH = bci_pkg::RESULT_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    pop_valid,
	output logic                    pop_ready,
	input  bci_pkg::job_t           pop_data,
	output logic                    res_valid,
	input  logic                    res_ready,
	output logic [RESULT_WIDTH-1:0] coefficient
);

	localparam int FW      = bci_pkg::FIELD_W;
	localparam int RB      = bci_pkg::RADIX_BITS;
	localparam int PW      = RESULT_WIDTH + FW;
	localparam int DW      = ((PW + RB - 1) / RB) * RB;
	localparam int DIV_CYC = DW / RB;
	localparam int CW      = $clog2(DIV_CYC + 1);

	bci_pkg::state_t               state_q;
	bci_pkg::state_t               state_nx;
	logic [RESULT_WIDTH-1:0]       acc_q;
	logic [FW-1:0]                 m_q;
	logic [FW-1:0]                 d_q;
	logic [bci_pkg::STEP_W-1:0]    cnt_q;
	logic [DW-1:0]                 dvd_q;
	logic [FW-1:0]                 rem_q;
	logic [CW-1:0]                 dcnt_q;
	logic [RESULT_WIDTH-1:0]       coefficient_q;
	logic                          res_valid_q;
	logic [PW-1:0]                 prod;
	logic [DW-1:0]                 dvd_nx;
	logic [FW-1:0]                 rem_nx;
	logic [FW:0]                   trial;
	logic                          ovf;
	logic                          out_take;

	assign prod        = PW'(acc_q) * PW'(m_q);
	assign ovf         = |dvd_q[DW-1:RESULT_WIDTH];
	assign out_take    = !res_valid_q || res_ready;
	assign res_valid   = res_valid_q;
	assign coefficient = coefficient_q;

	// restoring division, RB quotient bits per cycle
	always_comb begin
		dvd_nx = dvd_q;
		rem_nx = rem_q;
		trial  = '0;
		for (int j = 0; j < RB; j++) begin
			trial = {rem_nx, dvd_nx[DW-1]};
			if (trial >= {1'b0, d_q}) begin
				trial  = trial - {1'b0, d_q};
				rem_nx = trial[FW-1:0];
				dvd_nx = {dvd_nx[DW-2:0], 1'b1};
			end else begin
				rem_nx = trial[FW-1:0];
				dvd_nx = {dvd_nx[DW-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		state_nx  = state_q;
		pop_ready = 1'b0;
		unique case (state_q)
			bci_pkg::ST_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					state_nx = pop_data.trivial ? bci_pkg::ST_OUT : bci_pkg::ST_MUL;
				end
			end
			bci_pkg::ST_MUL: begin
				state_nx = bci_pkg::ST_DIV;
			end
			bci_pkg::ST_DIV: begin
				if (dcnt_q == CW'(DIV_CYC - 1)) begin
					state_nx = bci_pkg::ST_STEP;
				end
			end
			bci_pkg::ST_STEP: begin
				if (ovf || cnt_q == bci_pkg::STEP_W'(1)) begin
					state_nx = bci_pkg::ST_OUT;
				end else begin
					state_nx = bci_pkg::ST_MUL;
				end
			end
			bci_pkg::ST_OUT: begin
				if (out_take) begin
					state_nx = bci_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = bci_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bci_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == bci_pkg::ST_OUT && out_take) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			bci_pkg::ST_IDLE: begin
				if (pop_valid) begin
					acc_q <= pop_data.trivial ? RESULT_WIDTH'(pop_data.one)
					                          : RESULT_WIDTH'(1'b1);
					m_q   <= pop_data.n;
					d_q   <= FW'(1);
					cnt_q <= pop_data.kk;
				end
			end
			bci_pkg::ST_MUL: begin
				dvd_q  <= DW'(prod);
				rem_q  <= '0;
				dcnt_q <= '0;
			end
			bci_pkg::ST_DIV: begin
				dvd_q  <= dvd_nx;
				rem_q  <= rem_nx;
				dcnt_q <= dcnt_q + CW'(1);
			end
			bci_pkg::ST_STEP: begin
				acc_q <= ovf ? '1 : dvd_q[RESULT_WIDTH-1:0];
				m_q   <= m_q - FW'(1);
				d_q   <= d_q + FW'(1);
				cnt_q <= cnt_q - bci_pkg::STEP_W'(1);
			end
			bci_pkg::ST_OUT: begin
				if (out_take) begin
					coefficient_q <= acc_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== src/binomial_coefficient_iterative.sv =====
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// request   req_valid, req_ready   n [6:0], k [6:0]
// result    res_valid, res_ready   coefficient [RESULT_WIDTH-1:0]
//
// Edge cases (k above n, k zero, k equal to n) skip the loop and go straight to output.
// Otherwise j = min(k, n-k) steps, each a multiply, a restoring divide (4 quotient bits
// a cycle over RESULT_WIDTH+7 bits, rounded up to a multiple of 4) and an update;
// j is at most 63, and an overflow saturates the result to all ones and ends the loop.
// A two-entry queue between classifier and datapath absorbs stalls on either side.
// arst_n clears all control state; a stalled result holds in its output register.

module binomial_coefficient_iterative #(
	parameter int RESULT_WIDTH = bci_pkg::RESULT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [bci_pkg::FIELD_W-1:0] n,
	input  logic [bci_pkg::FIELD_W-1:0] k,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [RESULT_WIDTH-1:0]     coefficient
);

	logic          push_valid;
	logic          push_ready;
	bci_pkg::job_t push_data;
	logic          pop_valid;
	logic          pop_ready;
	bci_pkg::job_t pop_data;

	bci_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.n          (n),
		.k          (k),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	bci_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	bci_back #(
		.RESULT_WIDTH (RESULT_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_data    (pop_data),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.coefficient (coefficient)
	);

endmodule
